FILE: src/ssmb_pkg.sv
// Shared types and constants of the segment SHA-1 and minhash builder.
`timescale 1ns / 1ps
package ssmb_pkg;
   localparam int CHECKSUM_BYTES = 20;
   localparam int CK_WORDS = CHECKSUM_BYTES / 4;
   localparam logic [31:0] LIMIT_RESET = 32'd2097152;
   localparam logic [32:0] BYTES_MAX = 33'h1_FFFF_FFFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [31:0] PAD_WORD = 32'h8000_0000;
   localparam logic [3:0] LEN_HI_IDX = 4'd14;
   localparam logic [3:0] LEN_LO_IDX = 4'd15;
   localparam logic [4:0] LOAD_LAST = 5'd17;
   localparam logic [4:0] LOAD_WORDS = 5'd16;
   localparam logic [0:0] REG_LIMIT = 1'b0;
   localparam logic [0:0] REG_SKIP = 1'b1;

   typedef logic [4:0][31:0] word5_type;

   localparam word5_type SHA1_IV = {32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE,
                                    32'h1032_5476, 32'hC3D2_E1F0};

   typedef struct packed {
      logic load;
      logic start;
   } sha_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PAD_NONE,
      PAD_FIRST,
      PAD_SECOND
   } pad_type;
endpackage

FILE: src/ssmb_sha1_core.sv
// SHA-1 compression unit: sixteen-word schedule window and one round per cycle.
`timescale 1ns / 1ps
module ssmb_sha1_core
   import ssmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  sha_ctl_type ctl,
   input  logic [31:0] word_in,
   input  word5_type   h_in,
   output logic        done,
   output word5_type   h_out
);
   logic [15:0][31:0] w_ff, w_in;
   word5_type v_ff, v_in;
   logic [6:0] rnd_ff, rnd_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [31:0] f, k, t, nw, a, b, c, d, e;

   always_comb begin
      a = v_ff[4];
      b = v_ff[3];
      c = v_ff[2];
      d = v_ff[1];
      e = v_ff[0];
      if (rnd_ff < 7'd20) begin
         f = (b & c) | (~b & d);
         k = 32'h5A82_7999;
      end else if (rnd_ff < 7'd40) begin
         f = b ^ c ^ d;
         k = 32'h6ED9_EBA1;
      end else if (rnd_ff < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
         k = 32'h8F1B_BCDC;
      end else begin
         f = b ^ c ^ d;
         k = 32'hCA62_C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w_ff[0];
      nw = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      nw = {nw[30:0], nw[31]};
      w_in = w_ff;
      v_in = v_ff;
      rnd_in = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.load) begin
         w_in = {word_in, w_ff[15:1]};
      end
      if (ctl.start) begin
         v_in = h_in;
         rnd_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         w_in = {nw, w_ff[15:1]};
         v_in = {t, a, {b[1:0], b[31:2]}, c, d};
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == LAST_ROUND) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      for (int i = 0; i < 5; i++) begin
         h_out[i] = h_in[i] + v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      rnd_ff <= rnd_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
endmodule

FILE: src/segment_sha1_minhash_builder.sv
// Top level of the segment SHA-1 and minhash builder.
`timescale 1ns / 1ps
// Each item is one block record. A kept record writes its five checksum words into a
// 16-word message memory, one word a cycle; whenever the memory fills, one SHA-1
// compression runs (16 memory reads plus 80 rounds) before the writes go on. Closing a
// segment adds one or two padding compressions and a load of the result register. The
// input is stalled while a record is at work; a dropped record does not stall the input
// unless it closes the segment.
module segment_sha1_minhash_builder
   import ssmb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [63:0]  req_ck_bytes_0_7,
   input  logic [63:0]  req_ck_bytes_8_15,
   input  logic [31:0]  req_ck_bytes_16_19,
   input  logic [31:0]  req_block_size,
   input  logic [63:0]  req_block_offset,
   input  logic         req_end_segment,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_digest_bytes_0_7,
   output logic [63:0]  rsp_digest_bytes_8_15,
   output logic [31:0]  rsp_digest_bytes_16_19,
   output logic [63:0]  rsp_min_bytes_0_7,
   output logic [63:0]  rsp_min_bytes_8_15,
   output logic [31:0]  rsp_min_bytes_16_19,
   output logic [15:0]  rsp_min_position,
   output logic [63:0]  rsp_segment_offset,
   output logic [32:0]  rsp_segment_bytes,
   output logic [15:0]  rsp_segment_blocks,
   output logic         rsp_closed_by_limit,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   logic [31:0] msg_mem [16];
   logic [31:0] rd_data_ff;
   logic [3:0] rd_addr;
   logic wr_en;

   state_type state_ff, state_in;
   pad_type pad_ff, pad_in;
   logic [31:0] limit_ff;
   logic skip_ff;
   word5_type hash_ff, hash_in, ck_ff, ck_in, min_ff, min_in;
   logic [3:0] widx_ff, widx_in;
   logic [2:0] kw_ff, kw_in;
   logic [4:0] lc_ff, lc_in;
   logic [31:0] count_ff, count_in;
   logic [32:0] bytes_ff, bytes_in;
   logic [15:0] blocks_ff, blocks_in, pos_ff, pos_in;
   logic [63:0] first_ff, first_in;
   logic close_ff, close_in, bylim_ff, bylim_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_load;
   word5_type rsp_dig_ff, rsp_min_ff;
   logic [15:0] rsp_pos_ff, rsp_blocks_ff;
   logic [63:0] rsp_off_ff;
   logic [32:0] rsp_bytes_ff;
   logic rsp_lim_ff;

   sha_ctl_type sha_ctl;
   logic [31:0] sha_word;
   logic sha_done;
   word5_type sha_sum;

   logic accept, keep, blocks0, smaller, limit_hit;
   logic [33:0] bytes_sum;
   logic [32:0] bytes_new;
   logic [3:0] push_idx;
   word5_type req_ck;

   assign req_ck = {req_ck_bytes_0_7, req_ck_bytes_8_15, req_ck_bytes_16_19};
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SKIP) ? {31'd0, skip_ff} : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         skip_ff <= 1'b1;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_LIMIT) begin
            limit_ff <= pwdata;
         end else begin
            skip_ff <= pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         msg_mem[widx_ff] <= ck_ff[3'd4 - kw_ff];
      end
      rd_data_ff <= msg_mem[rd_addr];
   end

   ssmb_sha1_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sha_ctl),
      .word_in (sha_word),
      .h_in    (hash_ff),
      .done    (sha_done),
      .h_out   (sha_sum)
   );

   always_comb begin
      keep = !(skip_ff && (req_block_size == 32'd0));
      blocks0 = (blocks_ff == 16'd0);
      smaller = blocks0 || (req_ck < min_ff);
      bytes_sum = {1'b0, bytes_ff} + {2'b00, req_block_size};
      bytes_new = bytes_sum[33] ? BYTES_MAX : bytes_sum[32:0];
      limit_hit = (bytes_new >= {1'b0, limit_ff});
      push_idx = lc_ff[3:0] - 4'd1;
      rd_addr = lc_ff[3:0];

      case (pad_ff)
         PAD_FIRST: begin
            if (push_idx < widx_ff) begin
               sha_word = rd_data_ff;
            end else if (push_idx == widx_ff) begin
               sha_word = PAD_WORD;
            end else if (widx_ff < LEN_HI_IDX && push_idx == LEN_HI_IDX) begin
               sha_word = {29'd0, count_ff[31:29]};
            end else if (widx_ff < LEN_HI_IDX && push_idx == LEN_LO_IDX) begin
               sha_word = {count_ff[28:0], 3'd0};
            end else begin
               sha_word = '0;
            end
         end
         PAD_SECOND: begin
            if (push_idx == LEN_HI_IDX) begin
               sha_word = {29'd0, count_ff[31:29]};
            end else if (push_idx == LEN_LO_IDX) begin
               sha_word = {count_ff[28:0], 3'd0};
            end else begin
               sha_word = '0;
            end
         end
         default: sha_word = rd_data_ff;
      endcase

      state_in = state_ff;
      pad_in = pad_ff;
      hash_in = hash_ff;
      ck_in = ck_ff;
      min_in = min_ff;
      widx_in = widx_ff;
      kw_in = kw_ff;
      lc_in = lc_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      blocks_in = blocks_ff;
      pos_in = pos_ff;
      first_in = first_ff;
      close_in = close_ff;
      bylim_in = bylim_ff;
      wr_en = 1'b0;
      sha_ctl = '0;
      rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ck_in = req_ck;
               kw_in = '0;
               if (keep) begin
                  if (blocks0) begin
                     first_in = req_block_offset;
                  end
                  if (smaller) begin
                     min_in = req_ck;
                     pos_in = blocks_ff;
                  end
                  bytes_in = bytes_new;
                  if (blocks_ff != COUNT_MAX) begin
                     blocks_in = blocks_ff + 16'd1;
                  end
                  count_in = count_ff + 32'(CHECKSUM_BYTES);
                  close_in = limit_hit || req_end_segment;
                  bylim_in = limit_hit;
                  state_in = ST_WRITE;
               end else if (req_end_segment && !blocks0) begin
                  close_in = 1'b1;
                  bylim_in = 1'b0;
                  pad_in = PAD_FIRST;
                  lc_in = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            widx_in = widx_ff + 4'd1;
            kw_in = kw_ff + 3'd1;
            lc_in = '0;
            if (widx_ff == LEN_LO_IDX) begin
               pad_in = PAD_NONE;
               state_in = ST_LOAD;
            end else if (kw_ff == 3'(CK_WORDS - 1)) begin
               if (close_ff) begin
                  pad_in = PAD_FIRST;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOAD: begin
            lc_in = lc_ff + 5'd1;
            sha_ctl.load = (lc_ff != 5'd0) && (lc_ff <= LOAD_WORDS);
            if (lc_ff == LOAD_LAST) begin
               sha_ctl.start = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            lc_in = '0;
            if (sha_done) begin
               hash_in = sha_sum;
               case (pad_ff)
                  PAD_NONE: begin
                     if (kw_ff != 3'(CK_WORDS)) begin
                        state_in = ST_WRITE;
                     end else if (close_ff) begin
                        pad_in = PAD_FIRST;
                        state_in = ST_LOAD;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  PAD_FIRST: begin
                     if (widx_ff >= LEN_HI_IDX) begin
                        pad_in = PAD_SECOND;
                        state_in = ST_LOAD;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               hash_in = SHA1_IV;
               min_in = '0;
               widx_in = '0;
               count_in = '0;
               bytes_in = '0;
               blocks_in = '0;
               pos_in = '0;
               first_in = '0;
               close_in = 1'b0;
               pad_in = PAD_NONE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ck_ff <= ck_in;
      kw_ff <= kw_in;
      lc_ff <= lc_in;
      bylim_ff <= bylim_in;
      if (rsp_load) begin
         rsp_dig_ff <= hash_ff;
         rsp_min_ff <= min_ff;
         rsp_pos_ff <= pos_ff;
         rsp_off_ff <= first_ff;
         rsp_bytes_ff <= bytes_ff;
         rsp_blocks_ff <= blocks_ff;
         rsp_lim_ff <= bylim_ff;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         pad_ff <= PAD_NONE;
         hash_ff <= SHA1_IV;
         min_ff <= '0;
         widx_ff <= '0;
         count_ff <= '0;
         bytes_ff <= '0;
         blocks_ff <= '0;
         pos_ff <= '0;
         first_ff <= '0;
         close_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pad_ff <= pad_in;
         hash_ff <= hash_in;
         min_ff <= min_in;
         widx_ff <= widx_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
         blocks_ff <= blocks_in;
         pos_ff <= pos_in;
         first_ff <= first_in;
         close_ff <= close_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_digest_bytes_0_7 = {rsp_dig_ff[4], rsp_dig_ff[3]};
   assign rsp_digest_bytes_8_15 = {rsp_dig_ff[2], rsp_dig_ff[1]};
   assign rsp_digest_bytes_16_19 = rsp_dig_ff[0];
   assign rsp_min_bytes_0_7 = {rsp_min_ff[4], rsp_min_ff[3]};
   assign rsp_min_bytes_8_15 = {rsp_min_ff[2], rsp_min_ff[1]};
   assign rsp_min_bytes_16_19 = rsp_min_ff[0];
   assign rsp_min_position = rsp_pos_ff;
   assign rsp_segment_offset = rsp_off_ff;
   assign rsp_segment_bytes = rsp_bytes_ff;
   assign rsp_segment_blocks = rsp_blocks_ff;
   assign rsp_closed_by_limit = rsp_lim_ff;
endmodule

FILE: src/ssmb_checker.sv
// Port-level checker of the segment SHA-1 and minhash builder, with its bind.
`timescale 1ns / 1ps
module ssmb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_min_position,
   input logic [15:0] rsp_segment_blocks,
   input logic [32:0] rsp_segment_bytes,
   input logic        rsp_closed_by_limit
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("A stalled result item was dropped.");

   a_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segment_blocks != 16'd0)
      else $error("A result item reports an empty segment.");

   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_position < rsp_segment_blocks) ||
                    (rsp_segment_blocks == 16'hFFFF))
      else $error("The minimum position lies outside the segment.");

   a_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("A result item appeared right after reset.");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closed_by_limit && rsp_segment_bytes == 33'd0 |->
         rsp_segment_blocks != 16'd0)
      else $error("A limit close reports no records.");
endmodule

bind segment_sha1_minhash_builder ssmb_checker u_ssmb_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_min_position    (rsp_min_position),
   .rsp_segment_blocks  (rsp_segment_blocks),
   .rsp_segment_bytes   (rsp_segment_bytes),
   .rsp_closed_by_limit (rsp_closed_by_limit)
);
